// ----- rtl/prescaled_timer_bank_assert.svh -----
// Assertion macros for the prescaled timer bank checker.
`ifndef PRESCALED_TIMER_BANK_ASSERT_SVH
`define PRESCALED_TIMER_BANK_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, held off during reset.
`define PTB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("prescaled_timer_bank: assertion failed");

// Next-cycle implication, sampled on clk_i, held off during reset.
`define PTB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("prescaled_timer_bank: assertion failed");

`endif

// ----- rtl/ptb_pkg.sv -----
// Shared types and constants of the prescaled timer bank.
`default_nettype none
package ptb_pkg;

  parameter int NUM_CHANNELS = 3;
  parameter int CNT_W        = 16;
  parameter int CH_W         = 2;
  parameter int PADDR_W      = 3;
  parameter int PDATA_W      = 32;

  parameter logic [CNT_W-1:0] TICKS_PER_SECOND_RST = 16'd1000;
  parameter logic [CNT_W-1:0] COUNT_CEILING_RST    = 16'd65000;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic {
    REG_TICKS_PER_SECOND = 1'b0,
    REG_COUNT_CEILING    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0] ticks_per_second;
    logic [CNT_W-1:0] count_ceiling;
  } cfg_t;

  typedef struct packed {
    op_e              opcode;
    logic [CH_W-1:0]  channel;
    logic [CNT_W-1:0] threshold;
    logic             periodic;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/ptb_cfg.sv -----
// APB configuration registers of the prescaled timer bank.
`default_nettype none
module ptb_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ptb_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [ptb_pkg::PDATA_W-1:0]     pwdata,
  output logic      [ptb_pkg::PDATA_W-1:0]     prdata,
  output logic                                 pready,
  output ptb_pkg::cfg_t                        cfg_o
);
  import ptb_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_second <= TICKS_PER_SECOND_RST;
      cfg_q.count_ceiling    <= COUNT_CEILING_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= pwdata[CNT_W-1:0];
        REG_COUNT_CEILING:    cfg_q.count_ceiling    <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_TICKS_PER_SECOND: prdata[CNT_W-1:0] = cfg_q.ticks_per_second;
      REG_COUNT_CEILING:    prdata[CNT_W-1:0] = cfg_q.count_ceiling;
      default:              prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/ptb_prescaler.sv -----
// Shared millisecond prescaler; pulses once per wrap.
`default_nettype none
module ptb_prescaler (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        tick_i,
  input  wire logic [ptb_pkg::CNT_W-1:0]   ticks_per_second_i,
  output logic                             advance_o
);
  import ptb_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             wrap;

  // A count at or above the wrap value wraps on the next tick.
  assign wrap      = count_q >= ticks_per_second_i;
  assign advance_o = tick_i && wrap;

  always_comb begin
    count_d = count_q;
    if (tick_i) begin
      count_d = wrap ? '0 : count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ptb_chan_bank.sv -----
// Per-channel seconds counters and run flags, with query compare.
`default_nettype none
module ptb_chan_bank (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_valid_i,
  input  wire ptb_pkg::cmd_t               cmd_i,
  input  wire logic                        advance_i,
  input  wire logic [ptb_pkg::CNT_W-1:0]   count_ceiling_i,
  output logic                             hit_o
);
  import ptb_pkg::*;

  logic [CNT_W-1:0]        seconds_q [NUM_CHANNELS];
  logic [CNT_W-1:0]        seconds_d [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] running_q, running_d;
  logic [NUM_CHANNELS-1:0] sel, hit;

  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      // An out-of-range channel selects nothing.
      sel[k] = cmd_valid_i && (32'(cmd_i.channel) == k);
      hit[k] = sel[k] && (cmd_i.opcode == OP_QUERY) && running_q[k] &&
               (seconds_q[k] >= cmd_i.threshold);
      seconds_d[k] = seconds_q[k];
      running_d[k] = running_q[k];
      if (cmd_valid_i) begin
        case (cmd_i.opcode)
          OP_TICK: begin
            if (advance_i && running_q[k] && (seconds_q[k] < count_ceiling_i)) begin
              seconds_d[k] = seconds_q[k] + CNT_W'(1);
            end
          end
          OP_START: begin
            if (sel[k]) begin
              seconds_d[k] = '0;
              running_d[k] = 1'b1;
            end
          end
          OP_STOP: begin
            if (sel[k]) begin
              running_d[k] = 1'b0;
            end
          end
          OP_QUERY: begin
            if (hit[k]) begin
              if (cmd_i.periodic) begin
                seconds_d[k] = '0;
              end else begin
                running_d[k] = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign hit_o = |hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        seconds_q[k] <= '0;
      end
    end else begin
      running_q <= running_d;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        seconds_q[k] <= seconds_d[k];
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/prescaled_timer_bank.sv -----
// Top level of the prescaled timer bank.
//
// A bank of seconds timers sharing one millisecond prescaler.
// Request channel: drive opcode_i, channel_i, threshold_i and periodic_i
// with start high; the request is taken at the rising edge where start is
// high and busy is low. busy is always low, so a request may be issued in
// every cycle: throughput is one request per clock.
// Opcodes: tick advances the prescaler (and, on wrap, every running count
// below count_ceiling), start clears and runs a channel, stop halts it, query
// compares a running count against threshold_i, reports expired_o, and on a
// hit clears a periodic channel or stops a one-shot one. The request lands in
// an input register when taken; from there it updates timer state and loads
// the result register, and done_o with expired_o is shown for exactly one
// cycle. One result per request, in request order. The receiver cannot stall:
// results are never held, so the result register simply reloads every cycle.
// Configuration: APB registers ticks_per_second (0x0) and count_ceiling
// (0x4); the user writes them only while no request is in flight; unenforced.
// Reset (rst_ni low, asynchronous): prescaler and all counts zero, all
// channels stopped, registers at 1000 and 65000, no result pending.
`default_nettype none
module prescaled_timer_bank (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  opcode_i,
  input  wire logic [ptb_pkg::CH_W-1:0]    channel_i,
  input  wire logic [ptb_pkg::CNT_W-1:0]   threshold_i,
  input  wire logic                        periodic_i,
  output logic                             done_o,
  output logic                             expired_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ptb_pkg::PADDR_W-1:0] paddr,
  input  wire logic [ptb_pkg::PDATA_W-1:0] pwdata,
  output logic      [ptb_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);
  import ptb_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd_q;
  logic  cmd_valid_q;
  logic  accept;
  logic  advance;
  logic  hit;
  logic  done_q;
  logic  expired_q;

  // Never stall the request side.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  ptb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register: valid flag is reset, payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.opcode    <= op_e'(opcode_i);
      cmd_q.channel   <= channel_i;
      cmd_q.threshold <= threshold_i;
      cmd_q.periodic  <= periodic_i;
    end
  end

  // Prescaler only sees tick requests.
  ptb_prescaler u_prescaler (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .tick_i             (cmd_valid_q && (cmd_q.opcode == OP_TICK)),
    .ticks_per_second_i (cfg.ticks_per_second),
    .advance_o          (advance)
  );

  ptb_chan_bank u_chan_bank (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid_q),
    .cmd_i           (cmd_q),
    .advance_i       (advance),
    .count_ceiling_i (cfg.count_ceiling),
    .hit_o           (hit)
  );

  // Result register: strobe for one cycle per request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      expired_q <= 1'b0;
    end else begin
      done_q    <= cmd_valid_q;
      expired_q <= cmd_valid_q && hit;
    end
  end

  assign done_o    = done_q;
  assign expired_o = expired_q;

endmodule
`default_nettype wire

// ----- rtl/ptb_checker.sv -----
// Port-level checker for the prescaled timer bank, bound to the top level.
`default_nettype none
`include "prescaled_timer_bank_assert.svh"
module ptb_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] opcode_i,
  input wire logic [1:0] channel_i,
  input wire logic       done_o,
  input wire logic       expired_o
);
  import ptb_pkg::*;

  // Every taken request yields a result through the input and result registers.
  `PTB_ASSERT_NXT(a_req_to_done, start && !busy, ##1 done_o)
  // No result without an earlier taken request.
  `PTB_ASSERT_IMP(a_done_has_req, done_o, $past(start && !busy, 2))
  // Only a query can report expiry.
  `PTB_ASSERT_IMP(a_expired_query, done_o && expired_o, $past(opcode_i, 2) == OP_QUERY)
  // Expiry only for an existing channel.
  `PTB_ASSERT_IMP(a_expired_chan, done_o && expired_o, 32'($past(channel_i, 2)) < NUM_CHANNELS)

endmodule

bind prescaled_timer_bank ptb_checker u_ptb_checker (.*);
`default_nettype wire
